FILE: rtl/core/fept_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-edge prescaled timer package
// Shared beat types, command and register codes, and timer constants.
// ----------------------------------------------------------------------------
package fept_pkg;

	// Command codes carried by an input beat.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Register select codes.
	localparam logic [1:0] REG_DIVIDER = 2'd0;
	localparam logic [1:0] REG_COUNTER = 2'd1;
	localparam logic [1:0] REG_MODULO  = 2'd2;
	localparam logic [1:0] REG_CONTROL = 2'd3;

	// Divider bit watched for each clock-select value.
	localparam int SEL_BIT_0 = 9;
	localparam int SEL_BIT_1 = 3;
	localparam int SEL_BIT_2 = 5;
	localparam int SEL_BIT_3 = 7;

	// Control register layout and read-back ones.
	localparam int          CTRL_BITS     = 3;
	localparam int          CTRL_EN_BIT   = 2;
	localparam logic [7:0]  CTRL_READ_SET = 8'hF8;

	// Divider read view is always 16 bits wide; the upper byte is returned.
	localparam int DIV_VIEW_BITS = 16;

	// Reload delay: loaded on overflow, reload phase at or below the last value.
	localparam logic [3:0] DELAY_LOAD        = 4'd8;
	localparam logic [3:0] DELAY_RELOAD_LAST = 4'd4;

	// One input beat.
	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] reg_sel;
		logic [7:0] wdata;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] rdata;
		logic       irq;
	} res_t;

endpackage

FILE: rtl/core/fept_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-edge prescaled timer core
// Holds the divider, counter, modulo, control and reload-delay state and
// computes the result and next state for one beat combinationally.
// ----------------------------------------------------------------------------
module fept_core #(
	parameter int DIVIDER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  fept_pkg::req_t req,
	output fept_pkg::res_t res
);
	import fept_pkg::*;

	logic [DIVIDER_BITS-1:0] div_q, div_n;
	logic [7:0]              tc_q, tc_n;
	logic [7:0]              mod_q, mod_n;
	logic [CTRL_BITS-1:0]    ctrl_q, ctrl_n;
	logic [3:0]              delay_q, delay_n;

	// Timer input: enable AND the divider bit chosen by clock select.
	function automatic logic timer_in(input logic [DIVIDER_BITS-1:0] d,
					  input logic [CTRL_BITS-1:0] c);
		logic b;
		unique case (c[1:0])
			2'd0: b = d[SEL_BIT_0];
			2'd1: b = d[SEL_BIT_1];
			2'd2: b = d[SEL_BIT_2];
			default: b = d[SEL_BIT_3];
		endcase
		return c[CTRL_EN_BIT] & b;
	endfunction

	// Next state and result for the beat in the input register.
	always_comb begin
		logic [8:0]               inc;
		logic [DIV_VIEW_BITS-1:0] div_view;
		logic [CTRL_BITS-1:0]     nctrl;
		div_n   = div_q;
		tc_n    = tc_q;
		mod_n   = mod_q;
		ctrl_n  = ctrl_q;
		delay_n = delay_q;
		res     = '0;
		inc     = '0;
		div_view = DIV_VIEW_BITS'(div_q);
		nctrl    = req.wdata[CTRL_BITS-1:0];
		unique case (req.cmd)
			CMD_TICK: begin
				// Count down the reload delay; each reload phase reloads and interrupts.
				if (delay_q != 4'd0) begin
					delay_n = delay_q - 4'd1;
					if (delay_n <= DELAY_RELOAD_LAST) begin
						tc_n    = mod_q;
						res.irq = 1'b1;
					end
				end
				div_n = div_q + DIVIDER_BITS'(1);
				if (timer_in(div_q, ctrl_q) && !timer_in(div_n, ctrl_q)) begin
					inc  = {1'b0, tc_n} + 9'd1;
					tc_n = inc[7:0];
					if (inc[8]) begin
						delay_n = DELAY_LOAD;
					end
				end
			end
			CMD_READ: begin
				unique case (req.reg_sel)
					REG_DIVIDER: res.rdata = div_view[DIV_VIEW_BITS-1 -: 8];
					REG_COUNTER: res.rdata = tc_q;
					REG_MODULO:  res.rdata = mod_q;
					default:     res.rdata = CTRL_READ_SET | 8'(ctrl_q);
				endcase
			end
			CMD_WRITE: begin
				unique case (req.reg_sel)
					REG_DIVIDER: begin
						// Clearing the divider can itself make a falling edge.
						div_n = '0;
						if (timer_in(div_q, ctrl_q)) begin
							inc  = {1'b0, tc_q} + 9'd1;
							tc_n = inc[7:0];
							if (inc[8]) begin
								delay_n = DELAY_LOAD;
							end
						end
					end
					REG_COUNTER: begin
						// A write before the reload phase cancels it; during it the write is lost.
						if (delay_q > DELAY_RELOAD_LAST) begin
							delay_n = 4'd0;
						end
						if (delay_n == 4'd0) begin
							tc_n = req.wdata;
						end
					end
					REG_MODULO: begin
						mod_n = req.wdata;
					end
					default: begin
						// A control change that drops the input counts at once; carry reloads now.
						ctrl_n = nctrl;
						if (timer_in(div_q, ctrl_q) && !timer_in(div_q, nctrl)) begin
							inc = {1'b0, tc_q} + 9'd1;
							if (inc[8]) begin
								tc_n    = mod_q;
								res.irq = 1'b1;
							end else begin
								tc_n = inc[7:0];
							end
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// State registers, updated once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= '0;
			tc_q    <= '0;
			mod_q   <= '0;
			ctrl_q  <= '0;
			delay_q <= '0;
		end else if (fire) begin
			div_q   <= div_n;
			tc_q    <= tc_n;
			mod_q   <= mod_n;
			ctrl_q  <= ctrl_n;
			delay_q <= delay_n;
		end
	end

endmodule

FILE: rtl/core/falling_edge_prescaled_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling-edge prescaled timer
// Divider/counter/modulo/control timer with an input register, a combinational
// state update and a result register.
// ----------------------------------------------------------------------------
// The block takes one beat (tick, register read or register write) per clock
// and returns exactly one result beat for each, in order. Sustained rate is one
// beat per cycle while out_stall is low; a beat passes through the input
// register and then the result register before its result is valid. The rate is
// set by the timer state update, which completes each beat in time for the next
// beat to see it. A stall on the result side holds the result register and
// backs up into the input register, and then into in_stall. DIVIDER_BITS sets
// the width of the free-running divider (10 to 16); divider reads return bits
// 15..8 with missing upper bits read as zero.
module falling_edge_prescaled_timer #(
	parameter int DIVIDER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [1:0] reg_sel,
	input  logic [7:0] wdata,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rdata,
	output logic       irq
);
	import fept_pkg::*;

	logic s1_valid_q;
	req_t req_s1;
	res_t res;
	logic adv;
	logic fire;
	logic out_valid_q;
	res_t res_s2;

	// The result register can take a new beat when empty or being drained.
	assign adv      = !out_valid_q || !out_stall;
	assign fire     = s1_valid_q && adv;
	assign in_stall = s1_valid_q && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= '{cmd: cmd, reg_sel: reg_sel, wdata: wdata};
		end
	end

	// Timer state and combinational beat processing.
	fept_core #(
		.DIVIDER_BITS(DIVIDER_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.req   (req_s1),
		.res   (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign rdata     = res_s2.rdata;
	assign irq       = res_s2.irq;

	// Only ticks and control writes can raise the interrupt.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.irq) |->
			(req_s1.cmd == CMD_TICK ||
			 (req_s1.cmd == CMD_WRITE && req_s1.reg_sel == REG_CONTROL)))
		else $error("irq raised by a beat that cannot raise it");

	// Non-read beats always return zero read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.cmd != CMD_READ) |=> (out_valid && rdata == 8'd0))
		else $error("nonzero read data on a non-read beat");

	// Input back-pressure only occurs while the input register holds a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked beat");

endmodule
